// File: hdl/vgd_pkg.sv
package vgd_pkg;

  // defaults for the top level parameters
  localparam int unsigned VOXEL_SLOTS_DEF     = 4096;
  localparam int unsigned MAX_SCAN_POINTS_DEF = 131072;
  localparam int unsigned COORD_BITS_DEF      = 24;

  // fixed field widths
  localparam int unsigned SCALE_BITS   = 21;
  localparam int unsigned SCALE_FRAC   = 24;
  localparam int unsigned RANGE_BITS   = 48;
  localparam int unsigned INT_BITS     = 16;
  localparam int unsigned CFG_IDX_BITS = 3;
  localparam int unsigned HASH_BITS    = 32;

  // register reset values
  localparam logic [SCALE_BITS-1:0] SCALE_RESET     = 21'd167772;
  localparam logic [RANGE_BITS-1:0] MIN_RANGE_RESET = '0;
  localparam logic [RANGE_BITS-1:0] MAX_RANGE_RESET = '1;

  // per-axis hash multipliers
  localparam logic [HASH_BITS-1:0] HASH_MUL_X = 32'h9E3779B1;
  localparam logic [HASH_BITS-1:0] HASH_MUL_Y = 32'h85EBCA77;
  localparam logic [HASH_BITS-1:0] HASH_MUL_Z = 32'hC2B2AE3D;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_VOXEL_SCALE = 3'd0,
    CFG_MIN_RANGE   = 3'd1,
    CFG_MAX_RANGE   = 3'd2,
    CFG_RANGE_EN    = 3'd3,
    CFG_PASSTHROUGH = 3'd4
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_KEY,
    ST_CHK,
    ST_HASH,
    ST_PINIT,
    ST_PRD,
    ST_PCHK,
    ST_ENT,
    ST_LAT,
    ST_DIV,
    ST_OUT
  } vgd_state_e;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic echo;
    logic none_out;
    logic ord_rd;
    logic key_step;
    logic step_clr;
    logic hash_step;
    logic drop_ovf;
    logic probe_init;
    logic probe_rd;
    logic probe_chk;
    logic ent_rd;
    logic ent_lat;
    logic div_run;
    logic emit;
    logic clr_step;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic passthrough;
    logic none_avail;
    logic step_last;
    logic range_drop;
    logic scan_full;
    logic probe_again;
    logic div_all;
    logic last_out;
    logic clr_last;
  } sts_t;

  function automatic logic [HASH_BITS-1:0] hash_const(input logic [1:0] axis);
    case (axis)
      2'd0:    return HASH_MUL_X;
      2'd1:    return HASH_MUL_Y;
      default: return HASH_MUL_Z;
    endcase
  endfunction

endpackage

// File: hdl/voxel_grid_downsample.sv
// Voxel grid downsampler with centroid readout.
// Command channel: an item is taken at a rising edge with start high and busy
// low. kind 0 adds a point, kind 1 reads the next voxel centroid.
// Result channel: out_valid_o strobes each word for exactly one cycle; the
// receiver cannot stall, so it must take every strobed word.
// Config channel: cfg_valid_i/cfg_ready_o with cfg_index_i and cfg_data_i;
// ready is always high. Write only while the block is idle.
// An add runs the key step and the range and budget checks, then the hash and
// one probe plus one more per hash collision (each probe is one read and one
// compare/write on the entry memory); a passthrough add or an empty read answers
// straight from idle. A centroid read is paced by the bit-serial divider shared
// by the four averages.
// Reset and the final centroid of a readout start a sweep of the used flags,
// one slot per cycle, with busy high; config writes are still taken during
// the sweep.
module voxel_grid_downsample #(
  parameter int unsigned VOXEL_SLOTS     = vgd_pkg::VOXEL_SLOTS_DEF,
  parameter int unsigned MAX_SCAN_POINTS = vgd_pkg::MAX_SCAN_POINTS_DEF,
  parameter int unsigned COORD_BITS      = vgd_pkg::COORD_BITS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start,
  output logic                                 busy,
  input  logic                                 kind_i,
  input  logic signed [COORD_BITS-1:0]         coord_x_i,
  input  logic signed [COORD_BITS-1:0]         coord_y_i,
  input  logic signed [COORD_BITS-1:0]         coord_z_i,
  input  logic [vgd_pkg::INT_BITS-1:0]         intensity_i,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [vgd_pkg::CFG_IDX_BITS-1:0]     cfg_index_i,
  input  logic [vgd_pkg::RANGE_BITS-1:0]       cfg_data_i,
  output logic                                 out_valid_o,
  output logic signed [COORD_BITS-1:0]         out_x_o,
  output logic signed [COORD_BITS-1:0]         out_y_o,
  output logic signed [COORD_BITS-1:0]         out_z_o,
  output logic [vgd_pkg::INT_BITS-1:0]         out_intensity_o,
  output logic [$clog2(MAX_SCAN_POINTS+1)-1:0] point_count_o,
  output logic                                 last_voxel_o,
  output logic                                 none_left_o,
  output logic                                 table_full_o
);

  import vgd_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready_o = 1'b1;

  vgd_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .kind_i  (kind_i),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (busy)
  );

  vgd_dp #(
    .VOXEL_SLOTS     (VOXEL_SLOTS),
    .MAX_SCAN_POINTS (MAX_SCAN_POINTS),
    .COORD_BITS      (COORD_BITS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .coord_x_i       (coord_x_i),
    .coord_y_i       (coord_y_i),
    .coord_z_i       (coord_z_i),
    .intensity_i     (intensity_i),
    .out_valid_o     (out_valid_o),
    .out_x_o         (out_x_o),
    .out_y_o         (out_y_o),
    .out_z_o         (out_z_o),
    .out_intensity_o (out_intensity_o),
    .point_count_o   (point_count_o),
    .last_voxel_o    (last_voxel_o),
    .none_left_o     (none_left_o),
    .table_full_o    (table_full_o)
  );

endmodule

// File: hdl/vgd_ram.sv
module vgd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hdl/vgd_div.sv
module vgd_div #(
  parameter int unsigned DW = 41,
  parameter int unsigned NW = 18
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [DW-1:0] dividend_i,
  input  logic [NW-1:0] divisor_i,
  output logic [DW-1:0] quotient_o,
  output logic          done_o
);

  localparam int unsigned CW = $clog2(DW + 1);

  logic [NW-1:0] rem_q;
  logic [DW-1:0] quo_q;
  logic [NW-1:0] dsr_q;
  logic [CW-1:0] cnt_q;
  logic          done_q;
  logic [NW:0]   trial;
  logic          fits;

  // restoring division, one quotient bit per cycle
  assign trial = {rem_q, quo_q[DW-1]};
  assign fits  = trial >= {1'b0, dsr_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        cnt_q <= CW'(DW);
      end else if (cnt_q != '0) begin
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dsr_q <= divisor_i;
    end else if (cnt_q != '0) begin
      rem_q <= fits ? NW'(trial - {1'b0, dsr_q}) : NW'(trial);
      quo_q <= {quo_q[DW-2:0], fits};
    end
  end

  assign quotient_o = quo_q;
  assign done_o     = done_q;

endmodule

// File: hdl/vgd_dp.sv
module vgd_dp #(
  parameter int unsigned VOXEL_SLOTS     = vgd_pkg::VOXEL_SLOTS_DEF,
  parameter int unsigned MAX_SCAN_POINTS = vgd_pkg::MAX_SCAN_POINTS_DEF,
  parameter int unsigned COORD_BITS      = vgd_pkg::COORD_BITS_DEF
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  vgd_pkg::cmd_t                          cmd_i,
  output vgd_pkg::sts_t                          sts_o,
  input  logic                                   cfg_valid_i,
  input  logic [vgd_pkg::CFG_IDX_BITS-1:0]       cfg_index_i,
  input  logic [vgd_pkg::RANGE_BITS-1:0]         cfg_data_i,
  input  logic signed [COORD_BITS-1:0]           coord_x_i,
  input  logic signed [COORD_BITS-1:0]           coord_y_i,
  input  logic signed [COORD_BITS-1:0]           coord_z_i,
  input  logic [vgd_pkg::INT_BITS-1:0]           intensity_i,
  output logic                                   out_valid_o,
  output logic signed [COORD_BITS-1:0]           out_x_o,
  output logic signed [COORD_BITS-1:0]           out_y_o,
  output logic signed [COORD_BITS-1:0]           out_z_o,
  output logic [vgd_pkg::INT_BITS-1:0]           out_intensity_o,
  output logic [$clog2(MAX_SCAN_POINTS+1)-1:0]   point_count_o,
  output logic                                   last_voxel_o,
  output logic                                   none_left_o,
  output logic                                   table_full_o
);

  import vgd_pkg::*;

  localparam int unsigned SB        = $clog2(VOXEL_SLOTS);
  localparam int unsigned CNT_BITS  = $clog2(MAX_SCAN_POINTS + 1);
  localparam int unsigned KEY_BITS  = COORD_BITS - 3;
  localparam int unsigned SUM_BITS  = COORD_BITS + CNT_BITS - 1;
  localparam int unsigned ISUM_BITS = INT_BITS + CNT_BITS - 1;
  localparam int unsigned PROD_BITS = COORD_BITS + SCALE_BITS + 1;
  localparam int unsigned SQ_BITS   = 2 * COORD_BITS;
  localparam int unsigned R2_BITS   = 2 * COORD_BITS + 2;
  localparam int unsigned ENT_W     = 3 * KEY_BITS + 3 * SUM_BITS + ISUM_BITS + CNT_BITS;

  // configuration registers
  logic [SCALE_BITS-1:0] scale_q;
  logic [RANGE_BITS-1:0] min_q, max_q;
  logic                  ren_q, pt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q <= SCALE_RESET;
      min_q   <= MIN_RANGE_RESET;
      max_q   <= MAX_RANGE_RESET;
      ren_q   <= 1'b0;
      pt_q    <= 1'b0;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_VOXEL_SCALE: scale_q <= cfg_data_i[SCALE_BITS-1:0];
        CFG_MIN_RANGE:   min_q   <= cfg_data_i;
        CFG_MAX_RANGE:   max_q   <= cfg_data_i;
        CFG_RANGE_EN:    ren_q   <= cfg_data_i[0];
        CFG_PASSTHROUGH: pt_q    <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // latched point
  logic signed [COORD_BITS-1:0] crd_q [3];
  logic [INT_BITS-1:0]          int_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      crd_q[0] <= coord_x_i;
      crd_q[1] <= coord_y_i;
      crd_q[2] <= coord_z_i;
      int_q    <= intensity_i;
    end
  end

  // key, range and hash steps: multiply axis n while folding in axis n-1
  logic [1:0]                  step_q;
  logic signed [PROD_BITS-1:0] prod_q;
  logic [SQ_BITS-1:0]          sq_q;
  logic [R2_BITS-1:0]          r2_q;
  logic signed [KEY_BITS-1:0]  key_q [3];
  logic [HASH_BITS-1:0]        hp_q, h_q;
  logic [1:0]                  prev_step;
  logic [HASH_BITS-1:0]        key_ext;

  assign prev_step = 2'(step_q - 2'd1);
  assign key_ext   = HASH_BITS'(key_q[step_q]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
    end else if (cmd_i.load || cmd_i.step_clr) begin
      step_q <= '0;
    end else if (cmd_i.key_step || cmd_i.hash_step) begin
      step_q <= 2'(step_q + 2'd1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      r2_q <= '0;
    end else if (cmd_i.key_step) begin
      if (step_q != 2'd3) begin
        prod_q <= PROD_BITS'($signed(crd_q[step_q]) * $signed({1'b0, scale_q}));
        sq_q   <= SQ_BITS'(crd_q[step_q] * crd_q[step_q]);
      end
      if (step_q != 2'd0) begin
        // arithmetic shift is a true floor
        key_q[prev_step] <= prod_q[SCALE_FRAC+KEY_BITS-1:SCALE_FRAC];
        r2_q             <= r2_q + R2_BITS'(sq_q);
      end
    end
    if (cmd_i.step_clr) begin
      h_q <= '0;
    end else if (cmd_i.hash_step) begin
      if (step_q != 2'd3) begin
        hp_q <= HASH_BITS'(key_ext * hash_const(step_q));
      end
      if (step_q != 2'd0) begin
        h_q <= h_q ^ hp_q;
      end
    end
  end

  // table memories
  logic              used_we, used_wdata, used_rdata;
  logic [SB-1:0]     used_waddr;
  logic              ent_we, ent_re;
  logic [SB-1:0]     ent_raddr;
  logic [ENT_W-1:0]  ent_wdata, ent_rdata;
  logic              ord_we;
  logic [SB-1:0]     ord_rdata;

  // table state
  logic [SB-1:0]       paddr_q, pcnt_q, clr_q;
  logic [SB:0]         total_q, pos_q;
  logic [CNT_BITS-1:0] scan_q;
  logic                ovf_q;

  // word read from an entry
  logic signed [KEY_BITS-1:0] rk_x, rk_y, rk_z;
  logic signed [SUM_BITS-1:0] rs_x, rs_y, rs_z;
  logic [ISUM_BITS-1:0]       rs_i;
  logic [CNT_BITS-1:0]        rcnt;

  assign {rk_x, rk_y, rk_z, rs_x, rs_y, rs_z, rs_i, rcnt} = ent_rdata;

  // probe decision
  logic slot_free, slot_match, create_ok, probe_again;
  logic signed [SUM_BITS-1:0] ws_x, ws_y, ws_z;
  logic [ISUM_BITS-1:0]       ws_i;
  logic [CNT_BITS-1:0]        wcnt;

  assign slot_free   = !used_rdata;
  assign slot_match  = used_rdata && rk_x == key_q[0] && rk_y == key_q[1] && rk_z == key_q[2];
  assign create_ok   = slot_free && (total_q < (SB+1)'(VOXEL_SLOTS));
  assign probe_again = !slot_free && !slot_match && (pcnt_q != SB'(VOXEL_SLOTS - 1));

  // new entry starts from zero sums, a hit adds to the stored ones
  assign ws_x = (slot_free ? SUM_BITS'(0) : rs_x) + SUM_BITS'(crd_q[0]);
  assign ws_y = (slot_free ? SUM_BITS'(0) : rs_y) + SUM_BITS'(crd_q[1]);
  assign ws_z = (slot_free ? SUM_BITS'(0) : rs_z) + SUM_BITS'(crd_q[2]);
  assign ws_i = (slot_free ? ISUM_BITS'(0) : rs_i) + ISUM_BITS'(int_q);
  assign wcnt = (slot_free ? CNT_BITS'(0) : rcnt) + CNT_BITS'(1);

  assign ent_wdata  = {key_q[0], key_q[1], key_q[2], ws_x, ws_y, ws_z, ws_i, wcnt};
  assign ent_we     = cmd_i.probe_chk && (create_ok || slot_match);
  assign ent_re     = cmd_i.probe_rd || cmd_i.ent_rd;
  assign ent_raddr  = cmd_i.ent_rd ? ord_rdata : paddr_q;
  assign ord_we     = cmd_i.probe_chk && create_ok;
  assign used_we    = cmd_i.clr_step || (cmd_i.probe_chk && create_ok);
  assign used_wdata = !cmd_i.clr_step;
  assign used_waddr = cmd_i.clr_step ? clr_q : paddr_q;

  vgd_ram #(.WIDTH(1), .DEPTH(VOXEL_SLOTS)) u_used_ram (
    .clk_i   (clk_i),
    .we_i    (used_we),
    .waddr_i (used_waddr),
    .wdata_i (used_wdata),
    .re_i    (cmd_i.probe_rd),
    .raddr_i (paddr_q),
    .rdata_o (used_rdata)
  );

  vgd_ram #(.WIDTH(ENT_W), .DEPTH(VOXEL_SLOTS)) u_ent_ram (
    .clk_i   (clk_i),
    .we_i    (ent_we),
    .waddr_i (paddr_q),
    .wdata_i (ent_wdata),
    .re_i    (ent_re),
    .raddr_i (ent_raddr),
    .rdata_o (ent_rdata)
  );

  // slot list in order of first appearance
  vgd_ram #(.WIDTH(SB), .DEPTH(VOXEL_SLOTS)) u_ord_ram (
    .clk_i   (clk_i),
    .we_i    (ord_we),
    .waddr_i (total_q[SB-1:0]),
    .wdata_i (paddr_q),
    .re_i    (cmd_i.ord_rd),
    .raddr_i (pos_q[SB-1:0]),
    .rdata_o (ord_rdata)
  );

  // centroid division: x, y, z, intensity one after another
  logic [SUM_BITS-1:0] dv_q [4];
  logic [SUM_BITS-1:0] qv_q [4];
  logic                neg_q [3];
  logic [CNT_BITS-1:0] n_q, cnt_q;
  logic [1:0]          idx_q;
  logic                go_q;
  logic [SUM_BITS-1:0] quo;
  logic                div_done;

  vgd_div #(.DW(SUM_BITS), .NW(CNT_BITS)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (go_q),
    .dividend_i (dv_q[idx_q]),
    .divisor_i  (n_q),
    .quotient_o (quo),
    .done_o     (div_done)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      go_q  <= 1'b0;
      idx_q <= '0;
    end else begin
      go_q <= 1'b0;
      if (cmd_i.ent_lat) begin
        go_q  <= 1'b1;
        idx_q <= '0;
      end else if (cmd_i.div_run && div_done && idx_q != 2'd3) begin
        go_q  <= 1'b1;
        idx_q <= 2'(idx_q + 2'd1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ent_lat) begin
      // divide magnitudes, restore sign after: truncation toward zero
      dv_q[0]  <= rs_x[SUM_BITS-1] ? SUM_BITS'(-rs_x) : SUM_BITS'(rs_x);
      dv_q[1]  <= rs_y[SUM_BITS-1] ? SUM_BITS'(-rs_y) : SUM_BITS'(rs_y);
      dv_q[2]  <= rs_z[SUM_BITS-1] ? SUM_BITS'(-rs_z) : SUM_BITS'(rs_z);
      dv_q[3]  <= SUM_BITS'(rs_i);
      neg_q[0] <= rs_x[SUM_BITS-1];
      neg_q[1] <= rs_y[SUM_BITS-1];
      neg_q[2] <= rs_z[SUM_BITS-1];
      n_q      <= (rcnt == '0) ? CNT_BITS'(1) : rcnt;
      cnt_q    <= rcnt;
    end
    if (cmd_i.div_run && div_done) begin
      qv_q[idx_q] <= quo;
    end
  end

  // table counters and probe address
  logic last_out;
  assign last_out = (pos_q + (SB+1)'(1)) == total_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= '0;
      pos_q   <= '0;
      scan_q  <= '0;
      ovf_q   <= 1'b0;
      clr_q   <= '0;
      paddr_q <= '0;
      pcnt_q  <= '0;
    end else begin
      if (cmd_i.clr_step) begin
        clr_q <= SB'(clr_q + SB'(1));
      end
      if (cmd_i.drop_ovf) begin
        ovf_q <= 1'b1;
      end
      if (cmd_i.probe_init) begin
        paddr_q <= h_q[SB-1:0];
        pcnt_q  <= '0;
      end
      if (cmd_i.probe_chk) begin
        if (create_ok) begin
          total_q <= total_q + (SB+1)'(1);
          scan_q  <= scan_q + CNT_BITS'(1);
        end else if (slot_match) begin
          scan_q <= scan_q + CNT_BITS'(1);
        end else if (probe_again) begin
          paddr_q <= SB'(paddr_q + SB'(1));
          pcnt_q  <= SB'(pcnt_q + SB'(1));
        end else begin
          ovf_q <= 1'b1;
        end
      end
      if (cmd_i.emit) begin
        if (last_out) begin
          total_q <= '0;
          pos_q   <= '0;
          scan_q  <= '0;
          ovf_q   <= 1'b0;
        end else begin
          pos_q <= pos_q + (SB+1)'(1);
        end
      end
    end
  end

  // signed centroid values
  logic signed [COORD_BITS-1:0] cen [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      cen[i] = neg_q[i] ? COORD_BITS'(SUM_BITS'(0) - qv_q[i]) : COORD_BITS'(qv_q[i]);
    end
  end

  // result word register
  logic                         out_valid_q, out_last_q, out_none_q, out_full_q;
  logic signed [COORD_BITS-1:0] out_x_q, out_y_q, out_z_q;
  logic [INT_BITS-1:0]          out_int_q;
  logic [CNT_BITS-1:0]          out_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= cmd_i.echo || cmd_i.none_out || cmd_i.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.echo) begin
      out_x_q    <= coord_x_i;
      out_y_q    <= coord_y_i;
      out_z_q    <= coord_z_i;
      out_int_q  <= intensity_i;
      out_cnt_q  <= CNT_BITS'(1);
      out_last_q <= 1'b0;
      out_none_q <= 1'b0;
      out_full_q <= ovf_q;
    end else if (cmd_i.none_out) begin
      out_x_q    <= '0;
      out_y_q    <= '0;
      out_z_q    <= '0;
      out_int_q  <= '0;
      out_cnt_q  <= '0;
      out_last_q <= 1'b0;
      out_none_q <= 1'b1;
      out_full_q <= ovf_q;
    end else if (cmd_i.emit) begin
      out_x_q    <= cen[0];
      out_y_q    <= cen[1];
      out_z_q    <= cen[2];
      out_int_q  <= qv_q[3][INT_BITS-1:0];
      out_cnt_q  <= cnt_q;
      out_last_q <= last_out;
      out_none_q <= 1'b0;
      out_full_q <= ovf_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_x_o         = out_x_q;
  assign out_y_o         = out_y_q;
  assign out_z_o         = out_z_q;
  assign out_intensity_o = out_int_q;
  assign point_count_o   = out_cnt_q;
  assign last_voxel_o    = out_last_q;
  assign none_left_o     = out_none_q;
  assign table_full_o    = out_full_q;

  // status; the wide range sum never wraps, so it compares like a saturated one
  always_comb begin
    sts_o             = '0;
    sts_o.passthrough = pt_q;
    sts_o.none_avail  = pos_q >= total_q;
    sts_o.step_last   = step_q == 2'd3;
    sts_o.range_drop  = ren_q && (r2_q < R2_BITS'(min_q) || r2_q > R2_BITS'(max_q));
    sts_o.scan_full   = scan_q >= CNT_BITS'(MAX_SCAN_POINTS);
    sts_o.probe_again = probe_again;
    sts_o.div_all     = div_done && idx_q == 2'd3;
    sts_o.last_out    = last_out;
    sts_o.clr_last    = clr_q == SB'(VOXEL_SLOTS - 1);
  end

  a_none_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_none_q |-> out_cnt_q == '0)
    else $error("empty read word carries a point count");

  a_last_not_none: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_last_q |-> !out_none_q)
    else $error("final voxel word flagged as empty");

  a_total_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    total_q <= (SB+1)'(VOXEL_SLOTS))
    else $error("voxel count beyond table size");

  a_pos_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= total_q)
    else $error("readout position passed voxel count");

endmodule

// File: hdl/vgd_ctrl.sv
module vgd_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic          kind_i,
  input  vgd_pkg::sts_t sts_i,
  output vgd_pkg::cmd_t cmd_o,
  output logic          busy_o
);

  import vgd_pkg::*;

  vgd_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    busy_o  = 1'b1;
    case (state_q)
      // sweep the used flags
      ST_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        busy_o = 1'b0;
        if (start_i) begin
          if (!kind_i) begin
            if (sts_i.passthrough) begin
              cmd_o.echo = 1'b1;
            end else begin
              cmd_o.load = 1'b1;
              state_d    = ST_KEY;
            end
          end else if (sts_i.none_avail) begin
            cmd_o.none_out = 1'b1;
          end else begin
            cmd_o.ord_rd = 1'b1;
            state_d      = ST_ENT;
          end
        end
      end
      ST_KEY: begin
        cmd_o.key_step = 1'b1;
        if (sts_i.step_last) state_d = ST_CHK;
      end
      // range window, then point budget
      ST_CHK: begin
        if (sts_i.range_drop) begin
          state_d = ST_IDLE;
        end else if (sts_i.scan_full) begin
          cmd_o.drop_ovf = 1'b1;
          state_d        = ST_IDLE;
        end else begin
          cmd_o.step_clr = 1'b1;
          state_d        = ST_HASH;
        end
      end
      ST_HASH: begin
        cmd_o.hash_step = 1'b1;
        if (sts_i.step_last) state_d = ST_PINIT;
      end
      ST_PINIT: begin
        cmd_o.probe_init = 1'b1;
        state_d          = ST_PRD;
      end
      ST_PRD: begin
        cmd_o.probe_rd = 1'b1;
        state_d        = ST_PCHK;
      end
      ST_PCHK: begin
        cmd_o.probe_chk = 1'b1;
        state_d         = sts_i.probe_again ? ST_PRD : ST_IDLE;
      end
      ST_ENT: begin
        cmd_o.ent_rd = 1'b1;
        state_d      = ST_LAT;
      end
      ST_LAT: begin
        cmd_o.ent_lat = 1'b1;
        state_d       = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div_run = 1'b1;
        if (sts_i.div_all) state_d = ST_OUT;
      end
      ST_OUT: begin
        cmd_o.emit = 1'b1;
        state_d    = sts_i.last_out ? ST_CLEAR : ST_IDLE;
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

endmodule
